[rtl/core/bmb_pkg.sv]
package bmb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int ADDR_W = COL_W + ROW_W;
	localparam int SIZE_W = 9;
	localparam int TAB_W  = 24;
	localparam int CNT_W  = 2 * SIZE_W;
	localparam int RSUM_W = 16;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_HWX    = 2'd2;
	localparam logic [1:0] REG_HWY    = 2'd3;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] pix;
	} cmd_t;

endpackage

[rtl/core/bmb_queue.sv]
module bmb_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         flush,
	input  logic         in_valid,
	output logic         in_ready,
	input  bmb_pkg::cmd_t in_cmd,
	output logic         out_valid,
	input  logic         out_ready,
	output bmb_pkg::cmd_t out_cmd
);
	import bmb_pkg::*;

	cmd_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign out_cmd   = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (flush) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd0 |-> !out_valid)
		else $error("valid while empty");
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd0 || cnt_q == 3'd4) |-> wp_q == rp_q)
		else $error("pointer mismatch");

endmodule

[rtl/core/bmb_div.sv]
module bmb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bmb_pkg::TAB_W:0]   num,
	input  logic [bmb_pkg::CNT_W-1:0] den,
	output logic                      busy,
	output logic [bmb_pkg::TAB_W:0]   quo
);
	import bmb_pkg::*;

	localparam int NW = TAB_W + 1;

	logic [NW-1:0]     n_q;
	logic [CNT_W-1:0]  d_q;
	logic [CNT_W:0]    r_q;
	logic [4:0]        k_q;
	logic [CNT_W:0]    rs;

	assign busy = (k_q != 5'd0);
	assign quo  = n_q;
	assign rs   = {r_q[CNT_W-1:0], n_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (start) begin
			k_q <= 5'(NW);
		end else if (busy) begin
			k_q <= k_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy) begin
			if (rs >= {1'b0, d_q}) begin
				r_q <= rs - {1'b0, d_q};
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rs;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !start |-> r_q < {1'b0, d_q})
		else $error("remainder not below divisor");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> k_q == 5'(NW))
		else $error("divider did not load");

endmodule

[rtl/core/bmb_back.sv]
module bmb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  logic [bmb_pkg::SIZE_W-1:0] w_cfg,
	input  logic [bmb_pkg::SIZE_W-1:0] h_cfg,
	input  logic [7:0]                hwx,
	input  logic [7:0]                hwy,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  bmb_pkg::cmd_t             cmd,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_pix,
	output logic                      out_last,
	output logic                      out_status,
	output logic                      idle
);
	import bmb_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LDRD = 4'd1;
	localparam logic [3:0] S_LDWR = 4'd2;
	localparam logic [3:0] S_RDA  = 4'd3;
	localparam logic [3:0] S_RDB  = 4'd4;
	localparam logic [3:0] S_RDC  = 4'd5;
	localparam logic [3:0] S_RDD  = 4'd6;
	localparam logic [3:0] S_SUM  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_WAIT = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	logic [TAB_W-1:0] tab_q [MAX_WIDTH*MAX_HEIGHT];
	logic [TAB_W-1:0] rd_q;
	logic [ADDR_W-1:0] raddr, waddr;
	logic              re, we;
	logic [TAB_W-1:0]  wdata;

	logic [3:0]        st_q;
	logic [SIZE_W-1:0] lcol_q, lrow_q, ecol_q, erow_q;
	logic [RSUM_W-1:0] rsum_q;
	logic [7:0]        pix_q;
	logic [SIZE_W-1:0] xm_q, ym_q, xM_q, yM_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TAB_W-1:0]  acc_q;
	logic [SIZE_W-1:0] w, h;
	logic              loaded, last;
	logic [SIZE_W:0]   xp, yp;
	logic [SIZE_W-1:0] xm, ym, xM, yM;
	logic [RSUM_W-1:0] rsum_n;
	logic              dstart, dbusy;
	logic [TAB_W:0]    dquo;
	logic [TAB_W:0]    dnum;

	always_comb begin
		w = (w_cfg == '0) ? SIZE_W'(1) : (w_cfg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : w_cfg;
		h = (h_cfg == '0) ? SIZE_W'(1) : (h_cfg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : h_cfg;
	end
	assign loaded = lrow_q >= h;
	assign last   = (ecol_q == w - 1'b1) && (erow_q == h - 1'b1);

	always_comb begin
		xm = (ecol_q > {1'b0, hwx}) ? ecol_q - {1'b0, hwx} : '0;
		ym = (erow_q > {1'b0, hwy}) ? erow_q - {1'b0, hwy} : '0;
		xp = {1'b0, ecol_q} + {2'b0, hwx};
		yp = {1'b0, erow_q} + {2'b0, hwy};
		xM = (xp < {1'b0, w - 1'b1}) ? xp[SIZE_W-1:0] : w - 1'b1;
		yM = (yp < {1'b0, h - 1'b1}) ? yp[SIZE_W-1:0] : h - 1'b1;
	end

	assign rsum_n = (lcol_q == '0) ? {8'b0, pix_q} : rsum_q + {8'b0, pix_q};

	always_comb begin
		raddr = '0;
		re    = 1'b0;
		case (st_q)
			S_LDRD: begin
				re    = 1'b1;
				raddr = {ROW_W'(lrow_q - 1'b1), lcol_q[COL_W-1:0]};
			end
			S_RDA: begin
				re    = 1'b1;
				raddr = {ROW_W'(ym_q - 1'b1), COL_W'(xm_q - 1'b1)};
			end
			S_RDB: begin
				re    = 1'b1;
				raddr = {ROW_W'(ym_q - 1'b1), xM_q[COL_W-1:0]};
			end
			S_RDC: begin
				re    = 1'b1;
				raddr = {yM_q[ROW_W-1:0], COL_W'(xm_q - 1'b1)};
			end
			S_RDD: begin
				re    = 1'b1;
				raddr = {yM_q[ROW_W-1:0], xM_q[COL_W-1:0]};
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	assign we    = (st_q == S_LDWR);
	assign waddr = {lrow_q[ROW_W-1:0], lcol_q[COL_W-1:0]};
	assign wdata = {8'b0, rsum_n} + ((lrow_q != '0) ? rd_q : '0);

	always_ff @(posedge clk) begin
		if (we) tab_q[waddr] <= wdata;
		if (re) rd_q <= tab_q[raddr];
	end

	assign dnum   = {1'b0, acc_q} + {8'b0, cnt_q[CNT_W-1:1]};
	assign dstart = (st_q == S_DIV);
	assign cmd_ready = (st_q == S_IDLE) && !out_valid;
	assign idle = (st_q == S_IDLE) && !out_valid && !cmd_valid;

	bmb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.den    (cnt_q),
		.busy   (dbusy),
		.quo    (dquo)
	);

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				pix_q <= cmd.pix;
				xm_q  <= xm;
				ym_q  <= ym;
				xM_q  <= xM;
				yM_q  <= yM;
				acc_q <= '0;
			end
			S_RDA: cnt_q <= CNT_W'(xM_q - xm_q + 1'b1) * CNT_W'(yM_q - ym_q + 1'b1);
			S_RDB: if (xm_q != '0 && ym_q != '0) acc_q <= acc_q + rd_q;
			S_RDC: if (ym_q != '0) acc_q <= acc_q - rd_q;
			S_RDD: if (xm_q != '0) acc_q <= acc_q - rd_q;
			S_SUM: acc_q <= acc_q + rd_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			lcol_q     <= '0;
			lrow_q     <= '0;
			ecol_q     <= '0;
			erow_q     <= '0;
			rsum_q     <= '0;
			out_valid  <= 1'b0;
			out_pix    <= '0;
			out_last   <= 1'b0;
			out_status <= 1'b0;
		end else if (restart) begin
			st_q      <= S_IDLE;
			lcol_q    <= '0;
			lrow_q    <= '0;
			ecol_q    <= '0;
			erow_q    <= '0;
			rsum_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						if (cmd.op == OP_LOAD) begin
							if (!loaded) st_q <= S_LDRD;
						end else if (!loaded) begin
							out_valid  <= 1'b1;
							out_pix    <= '0;
							out_last   <= 1'b0;
							out_status <= 1'b1;
						end else begin
							st_q <= S_RDA;
						end
					end
				end
				S_LDRD: st_q <= S_LDWR;
				S_LDWR: begin
					rsum_q <= rsum_n;
					if (lcol_q + 1'b1 >= w) begin
						lcol_q <= '0;
						lrow_q <= lrow_q + 1'b1;
					end else begin
						lcol_q <= lcol_q + 1'b1;
					end
					st_q <= S_IDLE;
				end
				S_RDA: st_q <= S_RDB;
				S_RDB: st_q <= S_RDC;
				S_RDC: st_q <= S_RDD;
				S_RDD: st_q <= S_SUM;
				S_SUM: st_q <= S_DIV;
				S_DIV: st_q <= S_WAIT;
				S_WAIT: if (!dbusy) st_q <= S_OUT;
				S_OUT: begin
					out_valid  <= 1'b1;
					out_pix    <= dquo[7:0];
					out_last   <= last;
					out_status <= 1'b0;
					if (last) begin
						lcol_q <= '0;
						lrow_q <= '0;
						ecol_q <= '0;
						erow_q <= '0;
						rsum_q <= '0;
					end else if (ecol_q + 1'b1 >= w) begin
						ecol_q <= '0;
						erow_q <= erow_q + 1'b1;
					end else begin
						ecol_q <= ecol_q + 1'b1;
					end
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !restart |=> out_valid)
		else $error("result dropped");
	a_notready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status |-> !out_last && out_pix == '0)
		else $error("not-ready result carries data");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> cnt_q != '0)
		else $error("zero window count");

endmodule

[rtl/core/box_mean_blur_integral_core.sv]
// Channel   | Handshake              | Payload
// in        | in_valid / in_ready    | operation, pixel_value
// out       | out_valid / out_ready  | blurred_pixel, last_pixel, status
// cfg (APB) | psel/penable/pready    | paddr, pwdata, prdata
//
// A load reads the entry above and then writes the new entry. An emit is paced by
// four table reads on the single read port and the bit-serial divider that retires
// one quotient bit per cycle (25 bits). A not-ready emit is answered from the idle
// state without any table read. Reset is asynchronous and active low; the table is
// not cleared and is read only where written. A stalled result holds the back end
// while the four-entry queue keeps taking transfers until it is full.
module box_mean_blur_integral_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  pixel_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  blurred_pixel,
	output logic        last_pixel,
	output logic        status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bmb_pkg::*;

	logic [SIZE_W-1:0] width_q, height_q;
	logic [7:0]        hwx_q, hwy_q;
	logic              wr, restart;
	logic [1:0]        ridx;
	cmd_t              qin, qout;
	logic              qv, qr, idle;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign ridx   = paddr[3:2];
	// Writing either size register restarts loading and emitting.
	assign restart = wr && (ridx == REG_WIDTH || ridx == REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
			hwx_q    <= 8'd1;
			hwy_q    <= 8'd1;
		end else if (wr) begin
			case (ridx)
				REG_WIDTH:  width_q  <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q <= pwdata[SIZE_W-1:0];
				REG_HWX:    hwx_q    <= pwdata[7:0];
				REG_HWY:    hwy_q    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_WIDTH:  prdata = {23'b0, width_q};
			REG_HEIGHT: prdata = {23'b0, height_q};
			REG_HWX:    prdata = {24'b0, hwx_q};
			REG_HWY:    prdata = {24'b0, hwy_q};
			default:    prdata = '0;
		endcase
	end

	assign qin.op  = operation;
	assign qin.pix = pixel_value;

	// Front end: the queue takes each transfer and hands it to the back end in order.
	bmb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.flush     (restart),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (qin),
		.out_valid (qv),
		.out_ready (qr),
		.out_cmd   (qout)
	);

	// Back end: table update for loads, four reads and a division for emits once the image is loaded.
	bmb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (restart),
		.w_cfg      (width_q),
		.h_cfg      (height_q),
		.hwx        (hwx_q),
		.hwy        (hwy_q),
		.cmd_valid  (qv),
		.cmd_ready  (qr),
		.cmd        (qout),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pix    (blurred_pixel),
		.out_last   (last_pixel),
		.out_status (status),
		.idle       (idle)
	);

	a_idle_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> !out_valid)
		else $error("result survived restart");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !last_pixel)
		else $error("not-ready result marked last");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		idle |-> !out_valid)
		else $error("idle while result pending");

endmodule

[sim/box_blur_checker.sv]
`timescale 1ns / 100ps

module box_blur_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  pixel_value,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  blurred_pixel,
	input  logic        last_pixel,
	input  logic        status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending
);
	import bmb_pkg::*;

	typedef struct {
		logic [7:0] mean;
		logic       last;
		logic       not_ready;
	} blur_result_t;

	logic [TAB_W-1:0] area_sums [MAX_WIDTH*MAX_HEIGHT];
	blur_result_t     pending_means [$];

	logic [SIZE_W-1:0] width_reg, height_reg;
	logic [7:0]        radius_x, radius_y;
	int unsigned       ld_col, ld_row, em_col, em_row;
	logic [RSUM_W-1:0] row_sum;

	assign pending = pending_means.size();

	function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic logic [TAB_W-1:0] sum_at(int unsigned r, int unsigned c);
		return area_sums[r*MAX_WIDTH + c];
	endfunction

	function automatic void restart_image();
		ld_col = 0;
		ld_row = 0;
		em_col = 0;
		em_row = 0;
		row_sum = '0;
	endfunction

	// Advances the expected state by one accepted transfer and queues its result, if it has one.
	function automatic void predict_transfer(logic op, logic [7:0] pix);
		int unsigned w, h, xm, ym, xhi, yhi, cnt;
		logic [TAB_W-1:0] above, a, b, c, d, sum;
		blur_result_t r;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		if (op == OP_LOAD) begin
			if (ld_row >= h) return;
			row_sum = (ld_col == 0) ? RSUM_W'(pix) : row_sum + pix;
			above = (ld_row > 0) ? sum_at(ld_row - 1, ld_col) : '0;
			area_sums[ld_row*MAX_WIDTH + ld_col] = TAB_W'(row_sum) + above;
			ld_col++;
			if (ld_col >= w) begin
				ld_col = 0;
				ld_row++;
			end
			return;
		end
		if (ld_row < h) begin
			r.mean = '0;
			r.last = 1'b0;
			r.not_ready = 1'b1;
			pending_means.push_back(r);
			return;
		end
		xm  = (em_col > radius_x) ? em_col - radius_x : 0;
		ym  = (em_row > radius_y) ? em_row - radius_y : 0;
		xhi = (em_col + radius_x < w - 1) ? em_col + radius_x : w - 1;
		yhi = (em_row + radius_y < h - 1) ? em_row + radius_y : h - 1;
		cnt = (xhi - xm + 1) * (yhi - ym + 1);
		a = (xm > 0 && ym > 0) ? sum_at(ym - 1, xm - 1) : '0;
		b = (ym > 0) ? sum_at(ym - 1, xhi) : '0;
		c = (xm > 0) ? sum_at(yhi, xm - 1) : '0;
		d = sum_at(yhi, xhi);
		sum = d - b - c + a;
		r.mean = 8'((int'(sum) + cnt / 2) / cnt);
		r.last = (em_col == w - 1) && (em_row == h - 1);
		r.not_ready = 1'b0;
		pending_means.push_back(r);
		if (r.last) begin
			restart_image();
		end else begin
			em_col++;
			if (em_col >= w) begin
				em_col = 0;
				em_row++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		blur_result_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			width_reg  = 9'd256;
			height_reg = 9'd256;
			radius_x   = 8'd1;
			radius_y   = 8'd1;
			fail_count <= 0;
			restart_image();
			pending_means.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_WIDTH: begin
						width_reg = pwdata[SIZE_W-1:0];
						restart_image();
					end
					REG_HEIGHT: begin
						height_reg = pwdata[SIZE_W-1:0];
						restart_image();
					end
					REG_HWX: radius_x = pwdata[7:0];
					REG_HWY: radius_y = pwdata[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_transfer(operation, pixel_value);
			if (out_valid && out_ready) begin
				if (pending_means.size() == 0) begin
					$error("result transfer with nothing expected");
					errs++;
				end else begin
					e = pending_means.pop_front();
					if (blurred_pixel !== e.mean) begin
						$error("blurred_pixel: expected %0d, got %0d", e.mean, blurred_pixel);
						errs++;
					end
					if (last_pixel !== e.last) begin
						$error("last_pixel: expected %0d, got %0d", e.last, last_pixel);
						errs++;
					end
					if (status !== e.not_ready) begin
						$error("status: expected %0d, got %0d", e.not_ready, status);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
	import bmb_pkg::*;

	// Cycles without any transfer before the run is declared hung. The queue holds four
	// commands, and each emit waits for the divider and for any receiver stall.
	localparam int HANG_LIMIT = 5000;
	// Random stimulus starts no new image once this many input transfers are sent in total.
	localparam int ITEM_TARGET = 1050;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [7:0]  pixel_value;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  blurred_pixel;
	logic        last_pixel;
	logic        status;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int sent_items;
	int idle_cycles;
	int stall_left;
	bit quiet;

	box_mean_blur_integral_core DUT (.*);

	box_blur_checker checker_i (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .pixel_value,
		.out_valid, .out_ready, .blurred_pixel, .last_pixel, .status,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The receiver stalls in random bursts until the quiet tail of the run, where it
	// always accepts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(1, 14);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// The watchdog ends the run if no transfer happens on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sends one input transfer. A random gap, when taken, drops valid first, so valid
	// stays high back to back whenever there is no gap.
	task automatic send_op(logic op, logic [7:0] pix);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		pixel_value <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_items++;
	endtask

	// Holds the sender until every expected result has arrived, then lets the
	// block finish any load still in flight.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One image: configure, load every pixel with a few premature emits mixed in,
	// try some loads that must be ignored, then emit n_emit output pixels. A
	// partly emitted image is dropped by the size writes of the next one.
	task automatic run_image(logic [8:0] w, logic [8:0] h, logic [7:0] rx, logic [7:0] ry,
			int eff_w, int eff_h, int n_emit);
		int n;
		drain();
		reg_write(REG_WIDTH, 32'(w));
		reg_write(REG_HEIGHT, 32'(h));
		reg_write(REG_HWX, 32'(rx));
		reg_write(REG_HWY, 32'(ry));
		n = eff_w * eff_h;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_op(OP_EMIT, 8'($urandom));
			send_op(OP_LOAD, 8'($urandom));
		end
		repeat ($urandom_range(0, 2)) send_op(OP_LOAD, 8'($urandom));
		for (int i = 0; i < n_emit; i++)
			send_op(OP_EMIT, 8'($urandom));
	endtask

	initial begin
		int w, h;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_LOAD;
		pixel_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_items = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: an emit right after reset is not ready; then sizes at their
		// extremes, including zero and values past the maximum, and extreme radii.
		send_op(OP_EMIT, 8'hff);
		run_image(9'd1, 9'd1, 8'd0, 8'd0, 1, 1, 1);
		run_image(9'd3, 9'd2, 8'd255, 8'd255, 3, 2, 6);
		run_image(9'd511, 9'd0, 8'd255, 8'd0, 256, 1, 256);
		run_image(9'd0, 9'd300, 8'd0, 8'd255, 1, 256, 32);
		run_image(9'd4, 9'd3, 8'd1, 8'd1, 4, 3, 12);

		// Random part: small images with mostly small random radii, occasionally huge ones.
		while (sent_items < ITEM_TARGET) begin
			if (sent_items > ITEM_TARGET - 100)
				quiet = 1'b1;
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 8);
			run_image(9'(w), 9'(h),
				($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
				($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
				w, h, w * h);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
